FILE: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, item layout and controller/datapath interface types for
// the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int NUM_STOPS = COLUMNS / TAB_WIDTH;

    // internal widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);

    // item field widths
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int ATTR_W  = 8;

    // source address of a scroll copy can run past the screen
    localparam int SRC_W = $clog2(CELLS + ((1 << COUNT_W) - 1) * COLUMNS + 1);

    localparam int IN_ITEM_W  = OP_W + CHAR_W + COUNT_W + INDEX_W;
    localparam int IN_TDATA_W = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_ITEM_W = POS_W + CHAR_W + ATTR_W;
    localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // opcodes
    localparam logic [OP_W-1:0] OP_PRINT  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_SCROLL = 3'd2;
    localparam logic [OP_W-1:0] OP_ROWEND = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic [COUNT_W-1:0] scroll_count;
        logic [CHAR_W-1:0]  char_code;
        logic [OP_W-1:0]    opcode;
    } item_t;

    typedef struct packed {
        logic load;
        logic print;
        logic blank;
        logic clear_step;
        logic copy_step;
        logic copy_finish;
        logic scan_step;
        logic scan_finish;
        logic read_issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic              sweep_last;
        logic              copy_last;
        logic              scan_last;
        logic              need_scroll;
        logic [ROW_W-1:0]  row;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
    } stat_t;

    // next tab stop, capped at the column count
    function automatic logic [COL_W-1:0] tab_next(input logic [COL_W-1:0] col);
        int stop;
        logic [COL_W-1:0] res;
        res = COL_W'(COLUMNS);
        for (int i = NUM_STOPS; i >= 1; i--)
        begin
            stop = i * TAB_WIDTH;
            if (stop > int'(col) && stop < COLUMNS)
            begin
                res = COL_W'(stop);
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memories, cursor registers, sweep counter and read pipeline of the
// text console writer, driven by commands from the controller.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcw_pkg::cmd_t              cmd,
    input  tcw_pkg::item_t             item,
    input  logic [tcw_pkg::ATTR_W-1:0] text_attribute,
    output tcw_pkg::stat_t             st
);
    import tcw_pkg::*;

    // character and attribute bytes kept apart so a char can be zeroed alone
    logic [CHAR_W-1:0] char_mem [CELLS];
    logic [ATTR_W-1:0] attr_mem [CELLS];

    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  ch_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [INDEX_W-1:0] index_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [CNT_W-1:0] pipe_cnt_reg, pipe_cnt_next;
    logic             pipe_zero_reg, pipe_zero_next;
    logic [COL_W-1:0] last_reg, last_next;

    logic [CHAR_W-1:0] rd_char_reg;
    logic [ATTR_W-1:0] rd_attr_reg;

    logic              we_char, we_attr, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CHAR_W-1:0] wchar;
    logic [ATTR_W-1:0] wattr;

    logic [ADDR_W-1:0]  row_base, cur_addr;
    logic [COUNT_W-1:0] scroll_n;
    logic [SRC_W-1:0]   src;
    logic               src_live;
    logic               is_plain;
    logic               read_hit;
    logic               scan_hit;

    assign row_base = ADDR_W'(32'(row_reg) * COLUMNS);
    assign cur_addr = row_base + ADDR_W'(col_reg);
    assign scroll_n = (op_reg == OP_SCROLL) ? count_reg : COUNT_W'(1);
    assign src      = SRC_W'(cnt_reg) + SRC_W'(32'(scroll_n) * COLUMNS);
    // rows at or past the old last row come in blank
    assign src_live = src < SRC_W'((ROWS - 1) * COLUMNS);
    assign is_plain = (ch_reg != CH_BACKSPACE) && (ch_reg != CH_TAB) &&
                      (ch_reg != CH_RETURN) && (ch_reg != CH_NEWLINE);
    assign read_hit = (op_reg == OP_READ) && (32'(index_reg) < CELLS);
    assign scan_hit = pipe_vld_reg && (rd_char_reg != '0);

    // memory port selection
    always_comb
    begin
        we_char = 1'b0;
        we_attr = 1'b0;
        waddr   = cur_addr;
        wchar   = '0;
        wattr   = '0;
        re      = 1'b0;
        raddr   = cur_addr;
        if (cmd.clear_step)
        begin
            we_char = 1'b1;
            we_attr = 1'b1;
            waddr   = cnt_reg[ADDR_W-1:0];
        end
        if (cmd.print)
        begin
            if (ch_reg == CH_BACKSPACE)
            begin
                if (col_reg != '0)
                begin
                    we_char = 1'b1;
                    waddr   = cur_addr - ADDR_W'(1);
                end
            end
            else if (is_plain && 32'(col_reg) < COLUMNS)
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                wchar   = ch_reg;
                wattr   = text_attribute;
            end
        end
        if (cmd.blank)
        begin
            if (32'(col_reg) < COLUMNS && 32'(row_reg) < ROWS)
            begin
                we_char = 1'b1;
            end
        end
        if (cmd.copy_step)
        begin
            if (32'(cnt_reg) < CELLS && src_live)
            begin
                re    = 1'b1;
                raddr = src[ADDR_W-1:0];
            end
            if (pipe_vld_reg)
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                waddr   = pipe_cnt_reg[ADDR_W-1:0];
                wchar   = pipe_zero_reg ? '0 : rd_char_reg;
                wattr   = pipe_zero_reg ? '0 : rd_attr_reg;
            end
        end
        if (cmd.scan_step)
        begin
            if (32'(cnt_reg) < COLUMNS)
            begin
                re    = 1'b1;
                raddr = row_base + cnt_reg[ADDR_W-1:0];
            end
        end
        if (cmd.read_issue)
        begin
            if (32'(index_reg) < CELLS)
            begin
                re    = 1'b1;
                raddr = index_reg[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_char)
        begin
            char_mem[waddr] <= wchar;
        end
        if (we_attr)
        begin
            attr_mem[waddr] <= wattr;
        end
        if (re)
        begin
            rd_char_reg <= char_mem[raddr];
            rd_attr_reg <= attr_mem[raddr];
        end
    end

    // cursor, counter and pipeline
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        pipe_vld_next  = pipe_vld_reg;
        pipe_cnt_next  = pipe_cnt_reg;
        pipe_zero_next = pipe_zero_reg;
        last_next      = last_reg;
        if (cmd.load)
        begin
            cnt_next      = '0;
            pipe_vld_next = 1'b0;
            last_next     = '0;
        end
        if (cmd.print)
        begin
            if (ch_reg == CH_BACKSPACE)
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            else if (ch_reg == CH_TAB)
            begin
                col_next = tab_next(col_reg);
            end
            else if (ch_reg == CH_RETURN)
            begin
                col_next = '0;
            end
            else if (ch_reg == CH_NEWLINE)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else if (32'(col_reg) < COLUMNS)
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (cmd.clear_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (st.sweep_last)
            begin
                col_next = '0;
                row_next = '0;
            end
        end
        if (cmd.copy_step)
        begin
            if (32'(cnt_reg) < CELLS)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pipe_vld_next  = 32'(cnt_reg) < CELLS;
            pipe_cnt_next  = cnt_reg;
            pipe_zero_next = !src_live;
        end
        if (cmd.copy_finish)
        begin
            if (32'(row_reg) < 32'(scroll_n))
            begin
                row_next = '0;
                col_next = '0;
            end
            else
            begin
                row_next = row_reg - ROW_W'(scroll_n);
            end
        end
        if (cmd.scan_step)
        begin
            if (32'(cnt_reg) < COLUMNS)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pipe_vld_next = 32'(cnt_reg) < COLUMNS;
            pipe_cnt_next = cnt_reg;
            if (scan_hit)
            begin
                last_next = COL_W'(pipe_cnt_reg) + COL_W'(1);
            end
        end
        if (cmd.scan_finish)
        begin
            col_next = scan_hit ? COL_W'(pipe_cnt_reg) + COL_W'(1) : last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_cnt_reg  <= '0;
            pipe_zero_reg <= 1'b0;
            last_reg      <= '0;
            op_reg        <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_cnt_reg  <= pipe_cnt_next;
            pipe_zero_reg <= pipe_zero_next;
            last_reg      <= last_next;
            if (cmd.load)
            begin
                op_reg <= item.opcode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg    <= item.char_code;
            count_reg <= item.scroll_count;
            index_reg <= item.cell_index;
        end
    end

    assign st.sweep_last     = 32'(cnt_reg) == CELLS - 1;
    assign st.copy_last      = pipe_vld_reg && (32'(pipe_cnt_reg) == CELLS - 1);
    assign st.scan_last      = pipe_vld_reg && (32'(pipe_cnt_reg) == COLUMNS - 1);
    assign st.need_scroll    = 32'(row_reg) >= ROWS - 1;
    assign st.row            = row_reg;
    assign st.pos            = POS_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign st.cell_char      = read_hit ? rd_char_reg : '0;
    assign st.cell_attribute = read_hit ? rd_attr_reg : '0;

endmodule

FILE: sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer of the text console writer: clearing pass after reset,
// item dispatch, memory sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [tcw_pkg::OP_W-1:0] in_opcode,
    input  logic                     out_free,
    input  tcw_pkg::stat_t           st,
    output logic                     in_ready,
    output tcw_pkg::cmd_t            cmd
);
    import tcw_pkg::*;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_PRINT  = 9'b000000100,
        S_BLANK  = 9'b000001000,
        S_CLEAR  = 9'b000010000,
        S_SCROLL = 9'b000100000,
        S_ROWEND = 9'b001000000,
        S_READ   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clear_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_opcode)
                        OP_PRINT:  state_next = S_PRINT;
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_SCROLL: state_next = S_SCROLL;
                        OP_ROWEND: state_next = S_ROWEND;
                        OP_READ:   state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_PRINT:
            begin
                cmd.print  = 1'b1;
                state_next = S_BLANK;
            end
            S_BLANK:
            begin
                // blank the cell under the cursor, then scroll once at the bottom
                cmd.blank  = 1'b1;
                state_next = st.need_scroll ? S_SCROLL : S_DONE;
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCROLL:
            begin
                cmd.copy_step = 1'b1;
                if (st.copy_last)
                begin
                    cmd.copy_finish = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_ROWEND:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_last)
                begin
                    cmd.scan_finish = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: print, clear, scroll, row end and cell read
// commands over a stream interface, one result item per command.
// ----------------------------------------------------------------------------
// latency depends on the command: print runs the print and blank steps (and
// a scroll sweep when a line feed scrolls), read a read step, row end a scan
// of the row, clear and scroll a one-cell-per-cycle sweep, unused codes none.
// one item is in work at a time; the next is accepted the cycle after its
// result is handed to the output register, which a stalled receiver delays.
// reset: asynchronous, active low; a clearing pass over all CELLS (2000)
// cells zeroes the cell memories before the first item is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode, char_code, scroll_count, cell_index
    input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cursor_position, cell_char, cell_attribute
    output logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata
);
    import tcw_pkg::*;

    cmd_t  cmd;
    stat_t st;
    item_t item;
    logic  out_free;

    logic [ATTR_W-1:0]     attr_reg;
    logic                  out_valid_reg;
    logic [OUT_ITEM_W-1:0] out_data_reg;

    assign item     = item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    assign out_free = !out_valid_reg || m_axis_tready;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (item.opcode),
        .out_free  (out_free),
        .st        (st),
        .in_ready  (s_axis_tready),
        .cmd       (cmd)
    );

    tcw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .item           (item),
        .text_attribute (attr_reg),
        .st             (st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {st.cell_attribute, st.cell_char, st.pos};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    // one item in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_axis_tready))
        else $error("result loaded over a pending result");

    // the cursor sits above the last row between items
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (32'(st.row) < ROWS - 1))
        else $error("cursor row out of range while idle");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[POS_W-1:0]) <= CELLS))
        else $error("cursor position beyond the screen");

endmodule
